// ===== rtl/core/pgc_pkg.sv =====
// ----------------------------------------------------------------------------
// pgc_pkg: shared types and codes for the pointer gesture capture unit
// Event, configuration, state and result records plus the distance helper.
// ----------------------------------------------------------------------------
package pgc_pkg;

  // default size of the trajectory point store
  localparam int MAX_POINTS_DEF = 64;

  // event function codes
  localparam logic [2:0] FN_MOVE    = 3'd0;
  localparam logic [2:0] FN_DOWN    = 3'd1;
  localparam logic [2:0] FN_UP      = 3'd2;
  localparam logic [2:0] FN_TIMEOUT = 3'd3;
  localparam logic [2:0] FN_ARM     = 3'd4;

  // gesture phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_TENT   = 2'd1;
  localparam logic [1:0] PH_ACTIVE = 2'd2;

  // notice codes
  localparam logic [2:0] NT_NONE    = 3'd0;
  localparam logic [2:0] NT_BEGIN   = 3'd1;
  localparam logic [2:0] NT_CANCEL  = 3'd2;
  localparam logic [2:0] NT_END     = 3'd3;
  localparam logic [2:0] NT_TIMEOUT = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_TRIGGER  = 2'd0;
  localparam logic [1:0] CFG_ACT_DIST = 2'd1;
  localparam logic [1:0] CFG_SMP_DIST = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd3;

  // reset values of the configuration registers (distances kept squared)
  localparam logic [1:0]  TRIGGER_RST = 2'd0;
  localparam logic [23:0] ACT_SQ_RST  = 24'd25;
  localparam logic [23:0] SMP_SQ_RST  = 24'd144;
  localparam logic [15:0] TIMEOUT_RST = 16'd0;

  typedef struct packed {
    logic [2:0]         func;
    logic [1:0]         button;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic [31:0]        now_ms;
    logic               gate_ok;
    logic               self_inj;
  } evt_t;

  typedef struct packed {
    logic [1:0]  trigger;
    logic [23:0] act_sq;
    logic [23:0] smp_sq;
    logic [15:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic signed [16:0] start_x;
    logic signed [16:0] start_y;
    logic signed [16:0] last_x;
    logic signed [16:0] last_y;
    logic signed [16:0] smp_x;
    logic signed [16:0] smp_y;
    logic [31:0]        last_move_ms;
    logic               suppress;
    logic               replay;
  } state_t;

  typedef struct packed {
    logic               swallow;
    logic [2:0]         notice;
    logic               point_added;
    logic signed [16:0] point_x;
    logic signed [16:0] point_y;
  } res_t;

  // squared euclidean distance between two points
  function automatic logic [35:0] sq_dist(input logic signed [16:0] ax,
                                          input logic signed [16:0] ay,
                                          input logic signed [16:0] bx,
                                          input logic signed [16:0] by);
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [35:0] px;
    logic signed [35:0] py;
    dx = 18'(ax) - 18'(bx);
    dy = 18'(ay) - 18'(by);
    px = 36'(dx) * 36'(dx);
    py = 36'(dy) * 36'(dy);
    return $unsigned(px) + $unsigned(py);
  endfunction

endpackage

// ===== rtl/core/pgc_step.sv =====
// ----------------------------------------------------------------------------
// pgc_step: next-state and result logic for one pointer event
// Pure combinational step of the idle / tentative / active capture machine.
// ----------------------------------------------------------------------------
module pgc_step #(
  parameter int MAX_POINTS = pgc_pkg::MAX_POINTS_DEF,
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  pgc_pkg::cfg_t   cfg,
  input  pgc_pkg::evt_t   evt,
  input  pgc_pkg::state_t st,
  input  logic [CW-1:0]   cnt,
  output pgc_pkg::state_t st_nxt,
  output logic [CW-1:0]   cnt_nxt,
  output pgc_pkg::res_t   res
);

  logic            trk_on;
  logic            moved;
  logic            smp_hit;
  logic            act_hit;
  logic            room;
  logic            timed_out;
  logic            is_trig;
  logic [31:0]     elapsed;
  pgc_pkg::state_t trk_st;
  logic [CW-1:0]   trk_cnt;
  logic            trk_added;

  // distance and timing checks
  always_comb begin
    trk_on    = (st.phase == pgc_pkg::PH_TENT) || (st.phase == pgc_pkg::PH_ACTIVE);
    moved     = (evt.pos_x != st.last_x) || (evt.pos_y != st.last_y);
    smp_hit   = pgc_pkg::sq_dist(evt.pos_x, evt.pos_y, st.smp_x, st.smp_y)
                >= {12'd0, cfg.smp_sq};
    act_hit   = pgc_pkg::sq_dist(evt.pos_x, evt.pos_y, st.start_x, st.start_y)
                >= {12'd0, cfg.act_sq};
    room      = cnt < CW'(MAX_POINTS);
    elapsed   = evt.now_ms - st.last_move_ms;
    timed_out = (st.phase == pgc_pkg::PH_ACTIVE) && (cfg.timeout != 16'd0) &&
                (elapsed >= {16'd0, cfg.timeout});
    is_trig   = evt.button == cfg.trigger;
  end

  // movement tracking, shared by move and trigger-up events
  always_comb begin
    trk_st    = st;
    trk_cnt   = cnt;
    trk_added = 1'b0;
    if (trk_on) begin
      if (moved) begin
        trk_st.last_x       = evt.pos_x;
        trk_st.last_y       = evt.pos_y;
        trk_st.last_move_ms = evt.now_ms;
      end
      if (smp_hit && room) begin
        trk_st.smp_x = evt.pos_x;
        trk_st.smp_y = evt.pos_y;
        trk_cnt      = cnt + CW'(1);
        trk_added    = 1'b1;
      end
      if ((st.phase == pgc_pkg::PH_TENT) && act_hit) begin
        trk_st.phase = pgc_pkg::PH_ACTIVE;
      end
    end
  end

  // event dispatch
  always_comb begin
    st_nxt          = st;
    cnt_nxt         = cnt;
    res             = '0;
    res.notice      = pgc_pkg::NT_NONE;
    if (!evt.self_inj) begin
      case (evt.func)
        pgc_pkg::FN_DOWN: begin
          if (is_trig) begin
            st_nxt.suppress = 1'b0;
            st_nxt.replay   = 1'b0;
            if (evt.gate_ok) begin
              // start point is the first stored point; store is never full here
              st_nxt.phase        = pgc_pkg::PH_TENT;
              st_nxt.last_move_ms = evt.now_ms;
              st_nxt.start_x      = evt.pos_x;
              st_nxt.start_y      = evt.pos_y;
              st_nxt.last_x       = evt.pos_x;
              st_nxt.last_y       = evt.pos_y;
              st_nxt.smp_x        = evt.pos_x;
              st_nxt.smp_y        = evt.pos_y;
              cnt_nxt             = CW'(1);
              res.point_added     = 1'b1;
              res.notice          = pgc_pkg::NT_BEGIN;
              res.swallow         = 1'b1;
            end
          end
        end
        pgc_pkg::FN_MOVE: begin
          st_nxt          = trk_st;
          cnt_nxt         = trk_cnt;
          res.point_added = trk_added;
        end
        pgc_pkg::FN_UP: begin
          if (is_trig) begin
            if (st.suppress) begin
              // late release after a timeout
              if (st.replay) begin
                res.notice = pgc_pkg::NT_CANCEL;
              end
              st_nxt.suppress = 1'b0;
              st_nxt.replay   = 1'b0;
              res.swallow     = 1'b1;
            end else begin
              st_nxt          = trk_st;
              cnt_nxt         = trk_cnt;
              res.point_added = trk_added;
              if (trk_st.phase == pgc_pkg::PH_TENT) begin
                st_nxt.phase = pgc_pkg::PH_IDLE;
                res.notice   = pgc_pkg::NT_CANCEL;
                res.swallow  = 1'b1;
              end else if (trk_st.phase == pgc_pkg::PH_ACTIVE) begin
                st_nxt.phase = pgc_pkg::PH_IDLE;
                res.notice   = pgc_pkg::NT_END;
                res.swallow  = 1'b1;
              end
            end
          end
        end
        pgc_pkg::FN_TIMEOUT: begin
          if (timed_out) begin
            st_nxt.phase    = pgc_pkg::PH_IDLE;
            st_nxt.suppress = 1'b1;
            res.notice      = pgc_pkg::NT_TIMEOUT;
          end
        end
        pgc_pkg::FN_ARM: begin
          if (st.suppress) begin
            st_nxt.replay = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // sampled point goes out only with point_added
    if (res.point_added) begin
      res.point_x = evt.pos_x;
      res.point_y = evt.pos_y;
    end
  end

endmodule

// ===== rtl/core/pointer_gesture_capture_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// pointer_gesture_capture_fsm_unit: pointer gesture capture machine
// Pipeline: input register then result register; a stalled output holds the input.
// Throughput: one event per cycle while out_tready is high; the combinational state
// update in pgc_step closes the loop, so a new event may follow every cycle.
// Reset: synchronous active-low rst_n clears both stages, gesture state and
// restores configuration defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pointer_gesture_capture_fsm_unit #(
  parameter int MAX_POINTS = pgc_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input event stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // button[1:0], pos_x[18:2], pos_y[35:19],
                                  // now_ms[67:36], gate_ok[68], zero pad
  input  logic [3:0]  in_tuser,   // func[2:0], self_injected[3]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // swallow[0], point_added[1], point_x[18:2],
                                  // point_y[35:19], pt_total[42:36], zero pad
  output logic [2:0]  out_tuser,  // notice[2:0]
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  pgc_pkg::cfg_t   cfg_r;
  pgc_pkg::evt_t   s1_evt_r;
  logic            s1_valid_r;
  logic            s1_adv;
  pgc_pkg::state_t st_r;
  pgc_pkg::state_t st_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  pgc_pkg::res_t   res_nxt;
  pgc_pkg::res_t   out_res_r;
  logic [6:0]      out_cnt_r;
  logic            out_valid_r;

  // handshake: input stage advances whenever the result slot is free or drains
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  // configuration registers, distances held squared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger <= pgc_pkg::TRIGGER_RST;
      cfg_r.act_sq  <= pgc_pkg::ACT_SQ_RST;
      cfg_r.smp_sq  <= pgc_pkg::SMP_SQ_RST;
      cfg_r.timeout <= pgc_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgc_pkg::CFG_TRIGGER:  cfg_r.trigger <= cfg_wdata[1:0];
        pgc_pkg::CFG_ACT_DIST: cfg_r.act_sq  <= 24'(cfg_wdata[11:0]) * 24'(cfg_wdata[11:0]);
        pgc_pkg::CFG_SMP_DIST: cfg_r.smp_sq  <= 24'(cfg_wdata[11:0]) * 24'(cfg_wdata[11:0]);
        pgc_pkg::CFG_TIMEOUT:  cfg_r.timeout <= cfg_wdata;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_evt_r.func     <= in_tuser[2:0];
      s1_evt_r.self_inj <= in_tuser[3];
      s1_evt_r.button   <= in_tdata[1:0];
      s1_evt_r.pos_x    <= in_tdata[18:2];
      s1_evt_r.pos_y    <= in_tdata[35:19];
      s1_evt_r.now_ms   <= in_tdata[67:36];
      s1_evt_r.gate_ok  <= in_tdata[68];
    end
  end

  // event step logic
  pgc_step #(
    .MAX_POINTS(MAX_POINTS)
  ) u_step (
    .cfg    (cfg_r),
    .evt    (s1_evt_r),
    .st     (st_r),
    .cnt    (cnt_r),
    .st_nxt (st_nxt),
    .cnt_nxt(cnt_nxt),
    .res    (res_nxt)
  );

  // gesture state commits as the event moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      cnt_r <= '0;
    end else if (s1_adv) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res_nxt;
      out_cnt_r <= 7'(cnt_nxt);
    end
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.notice;
  assign out_tdata  = {5'd0, out_cnt_r, out_res_r.point_y, out_res_r.point_x,
                       out_res_r.point_added, out_res_r.swallow};

endmodule
